// ===== rtl/core/cbh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbh_pkg
// Shared types and constants for the character bigram histogram: class
// encoding, table geometry, request modes and the control structs that pass
// between the stream tracker, the count memory and the top level.
// ----------------------------------------------------------------------------
package cbh_pkg;

  // Character classes: 'a'..'z' are 0..25, everything else is space.
  localparam int unsigned NUM_CLASS   = 27;
  localparam int unsigned CLASS_W     = 5;
  localparam logic [CLASS_W-1:0] SPACE_CLASS = 5'd26;
  localparam logic [7:0] LOW_LETTER  = 8'd97;
  localparam logic [7:0] HIGH_LETTER = 8'd122;

  // Histogram table geometry.
  localparam int unsigned ENTRY_COUNT = NUM_CLASS * NUM_CLASS;
  localparam int unsigned ADDR_W      = $clog2(ENTRY_COUNT);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRY_COUNT - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(NUM_CLASS);

  // Counter and result widths.
  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned OUT_W           = 32;

  // Request modes.
  typedef enum logic [1:0] {
    MODE_CHAR  = 2'd0,
    MODE_EOT   = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  // Table sweep state.
  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } state_t;

  // Decoded operation for the request at the input.
  typedef struct packed {
    logic              bump;     // increment the entry at addr
    logic              is_read;  // read request
    logic              read_ok;  // read indices are inside the table
    logic [ADDR_W-1:0] addr;
  } stream_op_t;

  // Memory port control.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
  } mem_ctl_t;

endpackage

// ===== rtl/core/cbh_stream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbh_stream
// Tracks the text stream (previous class and first-character flag), decodes
// each request into a table operation and forms the table address.
// ----------------------------------------------------------------------------
module cbh_stream
  import cbh_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  logic [1:0]   mode,
  input  logic [7:0]   char_code,
  input  logic [4:0]   read_row,
  input  logic [4:0]   read_col,
  output stream_op_t   op
);

  logic [CLASS_W-1:0] prev_class;
  logic [CLASS_W-1:0] prev_class_next;
  logic               have_first;
  logic               have_first_next;
  logic [CLASS_W-1:0] cls;
  logic [CLASS_W-1:0] row;
  logic [CLASS_W-1:0] col;
  mode_t              mode_e;

  assign mode_e = mode_t'(mode);

  // Map the byte to its class.
  always_comb begin
    if (char_code >= LOW_LETTER && char_code <= HIGH_LETTER) begin
      cls = CLASS_W'(char_code - LOW_LETTER);
    end else begin
      cls = SPACE_CLASS;
    end
  end

  // Decode the request and work out the next stream state.
  always_comb begin
    prev_class_next = prev_class;
    have_first_next = have_first;
    op.bump         = 1'b0;
    op.is_read      = 1'b0;
    op.read_ok      = 1'b0;
    row             = prev_class;
    col             = cls;
    unique case (mode_e)
      MODE_CHAR: begin
        if (!have_first) begin
          prev_class_next = cls;
          have_first_next = 1'b1;
        end else if (!(prev_class == SPACE_CLASS && cls == SPACE_CLASS)) begin
          op.bump         = 1'b1;
          prev_class_next = cls;
        end
      end
      MODE_EOT: begin
        // A trailing letter pairs with space.
        col = SPACE_CLASS;
        if (have_first && prev_class != SPACE_CLASS) begin
          op.bump = 1'b1;
        end
        have_first_next = 1'b0;
        prev_class_next = SPACE_CLASS;
      end
      MODE_READ: begin
        row        = read_row;
        col        = read_col;
        op.is_read = 1'b1;
        op.read_ok = (read_row <= SPACE_CLASS) && (read_col <= SPACE_CLASS);
      end
      MODE_CLEAR: begin
        // The table sweep is run by the top level.
      end
      default: begin
      end
    endcase
    // Table index is row * 27 + col.
    op.addr = ADDR_W'({{(ADDR_W-CLASS_W){1'b0}}, row} * ROW_STRIDE)
            + ADDR_W'(col);
  end

  // Stream state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_class <= SPACE_CLASS;
      have_first <= 1'b0;
    end else if (take) begin
      prev_class <= prev_class_next;
      have_first <= have_first_next;
    end
  end

endmodule

// ===== rtl/core/cbh_count_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbh_count_mem
// Histogram counter storage: one write port and one registered read port,
// with a bypass that returns the data written in the same cycle as a read
// of the same entry.
// ----------------------------------------------------------------------------
module cbh_count_mem
  import cbh_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  mem_ctl_t               ctl,
  input  logic [COUNT_WIDTH-1:0] wr_data,
  output logic [COUNT_WIDTH-1:0] rd_data
);

  logic [COUNT_WIDTH-1:0] mem [ENTRY_COUNT];
  logic [COUNT_WIDTH-1:0] rd_q;
  logic [COUNT_WIDTH-1:0] byp_data;
  logic                   byp_hit;

  // Storage array with a synchronous read.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[ctl.rd_addr];
    end
  end

  // Capture a write that lands on the entry being read at the same edge.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      byp_hit  <= ctl.wr_en && (ctl.wr_addr == ctl.rd_addr);
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp_hit ? byp_data : rd_q;

endmodule

// ===== rtl/core/char_bigram_histogram.sv =====
`timescale 1ns / 1ps
// A read result goes through the read stage register and then the output register before
// out_valid rises.
// Throughput: one character or end-of-text request per cycle while no clearing pass runs; a read
// waits until the output register and the read stage are empty, so reads cannot overlap.
// Clear writes all 729 table entries, one entry per cycle through the single write port.
// Reset starts the same clearing pass; no request is accepted until it ends.
// ----------------------------------------------------------------------------
// char_bigram_histogram
// Counts character bigrams of a text stream into a 27x27 table of
// saturating counters held in one memory, updated by read-modify-write.
// ----------------------------------------------------------------------------
module char_bigram_histogram
  import cbh_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       mode,
  input  logic [7:0]       char_code,
  input  logic [4:0]       read_row,
  input  logic [4:0]       read_col,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OUT_W-1:0] pair_count
);

  state_t                 state;
  state_t                 state_next;
  logic                   clearing;
  logic [ADDR_W-1:0]      clr_addr;
  logic [ADDR_W-1:0]      clr_addr_next;
  logic                   take;
  stream_op_t             op;
  mem_ctl_t               mem_ctl;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic [COUNT_WIDTH-1:0] inc_data;
  logic [OUT_W-1:0]       clip_data;
  logic                   s1_bump;
  logic                   s1_read;
  logic                   s1_read_ok;
  logic [ADDR_W-1:0]      s1_addr;

  // Input handshake: nothing is taken while clearing; a read also needs a free output register and read stage.
  assign in_stall = clearing
                 || ((mode_t'(mode) == MODE_READ) && (out_valid || s1_read));
  assign take     = in_valid && !in_stall;

  cbh_stream u_stream (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .mode      (mode),
    .char_code (char_code),
    .read_row  (read_row),
    .read_col  (read_col),
    .op        (op)
  );

  // Sweep state machine: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (take && mode_t'(mode) == MODE_CLEAR) begin
          state_next = ST_CLEAR;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Sweep state machine: outputs.
  always_comb begin
    clearing      = 1'b0;
    clr_addr_next = '0;
    unique case (state)
      ST_CLEAR: begin
        clearing      = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
      end
      ST_RUN: begin
        clr_addr_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
    end
  end

  // Read stage: the entry is fetched in the cycle the request is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_bump <= 1'b0;
      s1_read <= 1'b0;
    end else begin
      s1_bump <= take && op.bump;
      s1_read <= take && op.is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_addr    <= op.addr;
      s1_read_ok <= op.read_ok;
    end
  end

  // Saturating increment of the fetched count.
  assign inc_data = (rd_data == {COUNT_WIDTH{1'b1}}) ? rd_data : rd_data + 1'b1;

  // The sweep owns the write port; earlier updates are wiped by it anyway.
  always_comb begin
    mem_ctl.rd_en   = take && (op.bump || (op.is_read && op.read_ok));
    mem_ctl.rd_addr = op.addr;
    if (clearing) begin
      mem_ctl.wr_en   = 1'b1;
      mem_ctl.wr_addr = clr_addr;
      wr_data         = '0;
    end else begin
      mem_ctl.wr_en   = s1_bump;
      mem_ctl.wr_addr = s1_addr;
      wr_data         = inc_data;
    end
  end

  cbh_count_mem #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // Limit wide counters to the result width.
  generate
    if (COUNT_WIDTH > OUT_W) begin : g_clip
      assign clip_data = (|rd_data[COUNT_WIDTH-1:OUT_W]) ? {OUT_W{1'b1}}
                                                        : rd_data[OUT_W-1:0];
    end else begin : g_ext
      assign clip_data = OUT_W'(rd_data);
    end
  endgenerate

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_read) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_read) begin
      pair_count <= s1_read_ok ? clip_data : '0;
    end
  end

`ifndef NO_ASSERTIONS
  // A read reaching the read stage always finds the output register free.
  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    s1_read |-> !out_valid)
    else $error("read result would overwrite a pending result");

  // A read in the read stage is presented on the next cycle.
  a_read_lands: assert property (@(posedge clk) disable iff (rst)
    s1_read |=> out_valid)
    else $error("read result was lost");

  // Reset always starts a full clearing pass from the first entry.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (state == ST_CLEAR) && (clr_addr == '0))
    else $error("reset did not start the clearing pass");

  // The sweep only ends after the last entry has been written.
  a_sweep_complete: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) ##1 (state == ST_RUN) |-> $past(clr_addr) == LAST_ADDR)
    else $error("clearing pass ended early");
`endif

endmodule
